// ----- hdl/least_loaded_arena_chooser_macros.svh -----
// Assertion macros for the least-loaded arena chooser checker.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef LEAST_LOADED_ARENA_CHOOSER_MACROS_SVH
`define LEAST_LOADED_ARENA_CHOOSER_MACROS_SVH

// same-cycle implication
`define LLAC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LLAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/llac_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the least-loaded arena chooser.
// No dependencies.
package llac_pkg;

    localparam int DEFAULT_MAX_SLOTS = 16;
    localparam int IDX_W             = 4;
    localparam int CNT_W             = 16;
    localparam int CFG_W             = 5;

    localparam logic [CFG_W-1:0] NUM_ARENAS_RST = 5'd16;

    localparam logic REQ_ACQUIRE = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [IDX_W-1:0] arena_index;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0] chosen_index;
        logic             created;
        logic             error;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_REL_RD,
        ST_REL_UPD
    } state_t;

endpackage

// ----- hdl/llac_cnt_mem.sv -----
`timescale 1ns / 1ps
// User-count memory: one write port, one read port, registered read data.
// Depends on llac_pkg.
module llac_cnt_mem #(
    parameter int DEPTH = llac_pkg::DEFAULT_MAX_SLOTS,
    parameter int AW    = 4
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [llac_pkg::CNT_W-1:0] wr_data,
    input  logic [AW-1:0]              rd_addr,
    output logic [llac_pkg::CNT_W-1:0] rd_data
);
    import llac_pkg::*;

    logic [CNT_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- hdl/least_loaded_arena_chooser.sv -----
`timescale 1ns / 1ps
// Least-loaded arena chooser: an acquire scans the configured slots, one memory read per
// slot, then writes back the chosen count; a release reads and updates one slot.
// busy is high from accept until the result strobe, which shows with busy low, so the
// next request may be accepted in the strobe cycle. Results cannot be stalled.
// Reset: slot 0 present, all counts zero, num_arenas = 16; no clearing pass.
module least_loaded_arena_chooser #(
    parameter int MAX_SLOTS = llac_pkg::DEFAULT_MAX_SLOTS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  llac_pkg::req_t             req,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [llac_pkg::CFG_W-1:0] cfg_data,
    output logic                       done,
    output llac_pkg::rsp_t             rsp
);
    import llac_pkg::*;

    localparam int DEPTH = (MAX_SLOTS < 16) ? MAX_SLOTS : 16;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CFG_W-1:0] DEPTH_C = CFG_W'(DEPTH);

    state_t             state_reg, state_next;
    logic [CFG_W-1:0]   num_arenas_reg;
    logic [DEPTH-1:0]   present_reg, present_next;
    logic [DEPTH-1:0]   cnt_vld_reg, cnt_vld_next;
    logic [AW-1:0]      rd_addr_reg, rd_addr_next;
    logic [AW-1:0]      chk_idx_reg;
    logic               chk_vld_reg;
    logic [AW-1:0]      best_idx_reg, best_idx_next;
    logic [CNT_W-1:0]   best_cnt_reg, best_cnt_next;
    logic [AW-1:0]      hole_idx_reg, hole_idx_next;
    logic               hole_found_reg, hole_found_next;
    req_t               req_reg, req_next;
    rsp_t               rsp_reg, rsp_next;
    logic               done_reg, done_next;

    logic               mem_wr_en;
    logic [AW-1:0]      mem_wr_addr;
    logic [CNT_W-1:0]   mem_wr_data;
    logic [CNT_W-1:0]   mem_rd_data;

    logic [CFG_W-1:0]   n_used;
    logic [AW-1:0]      last_idx;
    logic [CNT_W-1:0]   chk_cnt;
    logic [AW-1:0]      rel_addr;
    logic               rel_in_range;
    logic [CNT_W-1:0]   rel_cnt;
    logic               rel_err;
    logic               use_best;
    logic [AW-1:0]      pick;
    logic               accept;

    llac_cnt_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_cnt_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (rd_addr_reg),
        .rd_data (mem_rd_data)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = !busy;
    assign done      = done_reg;
    assign rsp       = rsp_reg;
    assign accept    = start && !busy;

    assign n_used   = (num_arenas_reg == '0) ? CFG_W'(1) :
                      ((num_arenas_reg > DEPTH_C) ? DEPTH_C : num_arenas_reg);
    assign last_idx = AW'(n_used - CFG_W'(1));

    assign chk_cnt      = cnt_vld_reg[chk_idx_reg] ? mem_rd_data : '0;
    assign rel_addr     = req_reg.arena_index[AW-1:0];
    assign rel_in_range = (32'(req_reg.arena_index) < DEPTH);
    assign rel_cnt      = cnt_vld_reg[rel_addr] ? mem_rd_data : '0;
    assign rel_err      = !rel_in_range || !present_reg[rel_addr] || (rel_cnt == '0);
    assign use_best     = (best_cnt_reg == '0) || !hole_found_reg;
    assign pick         = use_best ? best_idx_reg : hole_idx_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req.req_type == REQ_RELEASE) ? ST_REL_RD : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rd_addr_reg == last_idx)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:   state_next = ST_DECIDE;
            ST_DECIDE:  state_next = ST_IDLE;
            ST_REL_RD:  state_next = ST_REL_UPD;
            ST_REL_UPD: state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        present_next    = present_reg;
        cnt_vld_next    = cnt_vld_reg;
        rd_addr_next    = rd_addr_reg;
        best_idx_next   = best_idx_reg;
        best_cnt_next   = best_cnt_reg;
        hole_idx_next   = hole_idx_reg;
        hole_found_next = hole_found_reg;
        req_next        = req_reg;
        rsp_next        = rsp_reg;
        done_next       = 1'b0;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = pick;
        mem_wr_data     = '0;

        if (chk_vld_reg)
        begin
            if (chk_idx_reg == '0)
            begin
                best_idx_next = '0;
                best_cnt_next = chk_cnt;
            end
            else if (present_reg[chk_idx_reg])
            begin
                if (chk_cnt < best_cnt_reg)
                begin
                    best_idx_next = chk_idx_reg;
                    best_cnt_next = chk_cnt;
                end
            end
            else if (!hole_found_reg)
            begin
                hole_idx_next   = chk_idx_reg;
                hole_found_next = 1'b1;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next        = req;
                    hole_found_next = 1'b0;
                    rd_addr_next    = (req.req_type == REQ_RELEASE) ?
                                      req.arena_index[AW-1:0] : '0;
                end
            end
            ST_SCAN:
            begin
                if (rd_addr_reg != last_idx)
                begin
                    rd_addr_next = rd_addr_reg + AW'(1);
                end
            end
            ST_DECIDE:
            begin
                mem_wr_en    = 1'b1;
                mem_wr_addr  = pick;
                mem_wr_data  = use_best ?
                               ((best_cnt_reg == '1) ? best_cnt_reg : best_cnt_reg + CNT_W'(1)) :
                               CNT_W'(1);
                cnt_vld_next[pick] = 1'b1;
                present_next[pick] = 1'b1;
                rsp_next.chosen_index = IDX_W'(pick);
                rsp_next.created      = !use_best;
                rsp_next.error        = 1'b0;
                done_next             = 1'b1;
            end
            ST_REL_UPD:
            begin
                if (!rel_err)
                begin
                    mem_wr_en              = 1'b1;
                    mem_wr_addr            = rel_addr;
                    mem_wr_data            = rel_cnt - CNT_W'(1);
                    cnt_vld_next[rel_addr] = 1'b1;
                end
                rsp_next.chosen_index = req_reg.arena_index;
                rsp_next.created      = 1'b0;
                rsp_next.error        = rel_err;
                done_next             = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            num_arenas_reg <= NUM_ARENAS_RST;
            present_reg    <= DEPTH'(1);
            cnt_vld_reg    <= '0;
            chk_vld_reg    <= 1'b0;
            hole_found_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            present_reg    <= present_next;
            cnt_vld_reg    <= cnt_vld_next;
            chk_vld_reg    <= (state_reg == ST_SCAN);
            hole_found_reg <= hole_found_next;
            done_reg       <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                num_arenas_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg  <= rd_addr_next;
        chk_idx_reg  <= rd_addr_reg;
        best_idx_reg <= best_idx_next;
        best_cnt_reg <= best_cnt_next;
        hole_idx_reg <= hole_idx_next;
        req_reg      <= req_next;
        rsp_reg      <= rsp_next;
    end

endmodule

// ----- hdl/llac_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the least-loaded arena chooser, bound to the top level.
// Depends on llac_pkg and least_loaded_arena_chooser_macros.svh.
`include "least_loaded_arena_chooser_macros.svh"

module llac_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           cfg_ready,
    input logic           done,
    input llac_pkg::rsp_t rsp
);
    import llac_pkg::*;

    `LLAC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request accepted but busy low")
    `LLAC_ASSERT_NEXT(a_no_done_idle, !busy, !done, "result without request in flight")
    `LLAC_ASSERT_NOW(a_done_free, done, !busy, "result strobe while busy")
    `LLAC_ASSERT_NOW(a_cfg_idle, busy, !cfg_ready, "config ready while busy")
    `LLAC_ASSERT_NOW(a_rsp_flags, done, !(rsp.created && rsp.error), "created and error both set")

endmodule

bind least_loaded_arena_chooser llac_checker u_llac_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .done      (done),
    .rsp       (rsp)
);
